// File: design/nsp_pkg.sv
// Package for the fixed-point square root and x^0.75 core.
// Holds widths, the sequencer state type and shared constants; no dependencies.
`timescale 1ns / 1ps
package nsp_pkg;
    localparam int FRAC_BITS    = 16;
    localparam int NEWTON_STEPS = 4;
    localparam int MANT_FRAC    = 30;
    localparam int DATA_W       = 32;
    localparam int SCALE_LIMIT  = 16;
    localparam int STEP_W       = $clog2(NEWTON_STEPS + 1);

    localparam logic KIND_SQRT = 1'b0;
    localparam logic KIND_POW  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE,
        S_DIV_START,
        S_DIV_WAIT,
        S_ROOT_DONE,
        S_MUL,
        S_OUT
    } t_state;
endpackage

// File: design/nsp_divider.sv
// Radix-2 restoring divider: one quotient bit per cycle, 64-bit dividend over 32-bit divisor.
// Depends on nsp_pkg. Quotient is truncated to 32 bits; division by zero gives all ones.
`timescale 1ns / 1ps
module nsp_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [2*nsp_pkg::DATA_W-1:0] i_dividend,
    input  logic [nsp_pkg::DATA_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [nsp_pkg::DATA_W-1:0] o_quotient
);
    import nsp_pkg::*;
    localparam int DVD_W = 2 * DATA_W;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_dvd, n_dvd;
    logic [DATA_W-1:0] r_rem, n_rem;
    logic [DATA_W-1:0] r_dvs, n_dvs;
    logic [DATA_W-1:0] r_quo, n_quo;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [DATA_W:0]  trial;
    logic [DATA_W+1:0] diff;

    // Only the low quotient bits are kept; the remainder never reaches the divisor.
    always_comb begin
        n_dvd = r_dvd; n_rem = r_rem; n_dvs = r_dvs; n_quo = r_quo;
        n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        trial = {r_rem, r_dvd[DVD_W-1]};
        diff  = {1'b0, trial} - {2'b00, r_dvs};
        if (i_start) begin
            n_dvd = i_dividend; n_rem = '0; n_dvs = i_divisor;
            n_quo = '0; n_cnt = CNT_W'(DVD_W); n_busy = 1'b1;
        end else if (r_busy) begin
            n_dvd = {r_dvd[DVD_W-2:0], 1'b0};
            if (!diff[DATA_W+1]) begin
                n_rem = diff[DATA_W-1:0];
                n_quo = {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                n_rem = trial[DATA_W-1:0];
                n_quo = {r_quo[DATA_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd; r_rem <= n_rem; r_dvs <= n_dvs; r_quo <= n_quo;
    end

    always_comb begin
        if (r_dvs == '0)
            o_quotient = '1;
        else
            o_quotient = r_quo;
    end
    assign o_done = r_done;

    property p_done_from_busy;
        @(posedge i_clk) disable iff (!i_rst_n) r_done |-> $past(r_busy);
    endproperty
    a_done_from_busy: assert property (p_done_from_busy) else $error("done without busy");

    property p_start_busy;
        @(posedge i_clk) disable iff (!i_rst_n) i_start |=> r_busy;
    endproperty
    a_start_busy: assert property (p_start_busy) else $error("start did not set busy");

    property p_cnt_busy;
        @(posedge i_clk) disable iff (!i_rst_n) r_busy |-> (r_cnt != '0);
    endproperty
    a_cnt_busy: assert property (p_cnt_busy) else $error("busy with zero count");
endmodule

// File: design/nsp_multiplier.sv
// Shift-and-add multiplier, one multiplier bit per cycle, 32 x 32 to 64 bits.
// Depends on nsp_pkg.
`timescale 1ns / 1ps
module nsp_multiplier (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [nsp_pkg::DATA_W-1:0]   i_a,
    input  logic [nsp_pkg::DATA_W-1:0]   i_b,
    output logic                         o_done,
    output logic [2*nsp_pkg::DATA_W-1:0] o_product
);
    import nsp_pkg::*;
    localparam int CNT_W = $clog2(DATA_W + 1);

    logic [2*DATA_W-1:0] r_acc;
    logic [DATA_W-1:0]   r_mcand;
    logic [DATA_W-1:0]   r_mplier;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy, r_done;
    logic [DATA_W:0]     upper_sum;

    // Accumulator shifts right; the multiplicand is added into the upper half.
    assign upper_sum = {1'b0, r_acc[2*DATA_W-1:DATA_W]}
                     + (r_mplier[0] ? {1'b0, r_mcand} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DATA_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_acc    <= '0;
            r_mcand  <= i_a;
            r_mplier <= i_b;
        end else if (r_busy) begin
            r_acc    <= {upper_sum, r_acc[DATA_W-1:1]};
            r_mplier <= {1'b0, r_mplier[DATA_W-1:1]};
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

    property p_done_after_busy;
        @(posedge i_clk) disable iff (!i_rst_n) r_done |-> $past(r_busy);
    endproperty
    a_done_after_busy: assert property (p_done_after_busy) else $error("mul done early");

    property p_start_busy;
        @(posedge i_clk) disable iff (!i_rst_n) i_start |=> r_busy;
    endproperty
    a_start_busy: assert property (p_start_busy) else $error("mul start lost");

    property p_cnt_busy;
        @(posedge i_clk) disable iff (!i_rst_n) r_busy |-> (r_cnt != '0);
    endproperty
    a_cnt_busy: assert property (p_cnt_busy) else $error("mul busy with zero count");
endmodule

// File: design/newton_sqrt_and_pow075_core.sv
// Top level of the fixed-point square root and x^0.75 core.
// Depends on nsp_pkg, nsp_divider and nsp_multiplier.
//
// Usage: an input transaction on s_axis carries the operand (signed Q16.16) in
// s_axis_tdata and the kind in s_axis_tuser (0 square root, 1 power 0.75).
// One result transaction on m_axis follows, unsigned Q16.16 in m_axis_tdata.
// Items are handled one at a time. The operand is normalised by a power of
// four one step per cycle, then four Newton steps each use the shared
// bit-serial divider. A square root runs these steps once; power 0.75 runs
// two roots and a serial multiply. Nonpositive operands give zero. The
// result waits in an output register; while the receiver stalls no new item
// is taken. A synchronous active-low reset returns the core to idle and
// drops any pending result.
`timescale 1ns / 1ps
module newton_sqrt_and_pow075_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] operand
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] value_out
);
    import nsp_pkg::*;
    localparam int SC_W  = $clog2(SCALE_LIMIT + 1);
    localparam int WIDE  = 2 * DATA_W;

    t_state r_state, n_state;
    logic              r_kind;
    logic              r_second, n_second;
    logic [DATA_W-1:0] r_raw, n_raw;
    logic [DATA_W-1:0] r_s, n_s;
    logic [WIDE-1:0]   r_m, n_m;
    logic [WIDE-1:0]   r_y, n_y;
    logic [SC_W-1:0]   r_down, n_down;
    logic [SC_W-1:0]   r_up, n_up;
    logic [STEP_W-1:0] r_step, n_step;
    logic [DATA_W-1:0] r_out, n_out;
    logic              r_ovalid, n_ovalid;

    logic              div_start, div_done, mul_start, mul_done;
    logic [DATA_W-1:0] quotient;
    logic [WIDE-1:0]   product;
    logic [WIDE-1:0]   raw_w, root_w, sum_w;
    logic              in_acc;

    nsp_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_m << MANT_FRAC),
        .i_divisor  (r_y[DATA_W-1:0]),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    nsp_multiplier u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (r_s),
        .i_b       (r_out),
        .o_done    (mul_done),
        .o_product (product)
    );

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;
    assign raw_w         = {{DATA_W{1'b0}}, r_raw};
    assign sum_w         = r_y + {{DATA_W{1'b0}}, quotient};

    // Final rescale of the iterate by 2^(FRAC_BITS + down - up - MANT_FRAC).
    always_comb begin
        if (FRAC_BITS + int'(r_down) - int'(r_up) >= MANT_FRAC)
            root_w = r_y << (FRAC_BITS + int'(r_down) - int'(r_up) - MANT_FRAC);
        else
            root_w = r_y >> (MANT_FRAC - FRAC_BITS - int'(r_down) + int'(r_up));
    end

    always_comb begin
        n_state = r_state; n_second = r_second; n_raw = r_raw; n_s = r_s;
        n_m = r_m; n_y = r_y; n_down = r_down; n_up = r_up; n_step = r_step;
        n_out = r_out; n_ovalid = r_ovalid;
        div_start = 1'b0; mul_start = 1'b0;
        if (r_ovalid && m_axis_tready)
            n_ovalid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_raw = s_axis_tdata; n_second = 1'b0;
                    n_down = '0; n_up = '0;
                    if (s_axis_tdata[DATA_W-1] || s_axis_tdata == '0) begin
                        n_out = '0; n_ovalid = 1'b1;
                    end else begin
                        n_state = S_SCALE;
                    end
                end
            end
            S_SCALE: begin
                // One power-of-four step per cycle, up or down.
                if (raw_w > (WIDE'(1) << (FRAC_BITS + 1 + 2 * int'(r_down)))
                        && r_down < SC_W'(SCALE_LIMIT)) begin
                    n_down = r_down + 1'b1;
                end else if (r_down == '0 && r_up < SC_W'(SCALE_LIMIT)
                        && (raw_w << (2 * int'(r_up))) < (WIDE'(1) << (FRAC_BITS - 1))) begin
                    n_up = r_up + 1'b1;
                end else begin
                    if (MANT_FRAC - FRAC_BITS - 2 * int'(r_down) + 2 * int'(r_up) >= 0)
                        n_m = raw_w << (MANT_FRAC - FRAC_BITS - 2 * int'(r_down)
                                        + 2 * int'(r_up));
                    else
                        n_m = raw_w >> (FRAC_BITS - MANT_FRAC + 2 * int'(r_down)
                                        - 2 * int'(r_up));
                    n_y    = ((WIDE'(1) << MANT_FRAC) + n_m) >> 1;
                    n_step = '0;
                    n_state = S_DIV_START;
                end
            end
            S_DIV_START: begin
                div_start = 1'b1;
                n_state   = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    n_y    = sum_w >> 1;
                    n_step = r_step + 1'b1;
                    if (r_step == STEP_W'(NEWTON_STEPS - 1))
                        n_state = S_ROOT_DONE;
                    else
                        n_state = S_DIV_START;
                end
            end
            S_ROOT_DONE: begin
                if (r_kind == KIND_SQRT) begin
                    n_out = root_w[DATA_W-1:0]; n_ovalid = 1'b1; n_state = S_IDLE;
                end else if (!r_second) begin
                    n_s = root_w[DATA_W-1:0];
                    n_raw = root_w[DATA_W-1:0];
                    n_second = 1'b1; n_down = '0; n_up = '0;
                    if (root_w[DATA_W-1:0] == '0) begin
                        n_out = '0; n_ovalid = 1'b1; n_state = S_IDLE;
                    end else begin
                        n_state = S_SCALE;
                    end
                end else begin
                    n_out = root_w[DATA_W-1:0];
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                mul_start = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (mul_done) begin
                    n_out = product[FRAC_BITS +: DATA_W];
                    n_ovalid = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_second <= n_second;
        end
        if (in_acc)
            r_kind <= s_axis_tuser;
        r_raw <= n_raw; r_s <= n_s; r_m <= n_m; r_y <= n_y;
        r_down <= n_down; r_up <= n_up; r_step <= n_step; r_out <= n_out;
    end

    property p_out_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_ovalid && !m_axis_tready) |=> (r_ovalid && $stable(r_out));
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result changed under stall");

    property p_no_accept_busy;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state != S_IDLE) |-> !s_axis_tready;
    endproperty
    a_no_accept_busy: assert property (p_no_accept_busy) else $error("ready while busy");

    property p_sqrt_single;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_MUL) |-> (r_kind == KIND_POW && r_second);
    endproperty
    a_sqrt_single: assert property (p_sqrt_single) else $error("multiply in sqrt mode");
endmodule

// File: verif/tb_top.sv
// Testbench for the fixed-point square root and x^0.75 core.
// Depends on nsp_pkg and newton_sqrt_and_pow075_core; checks each result against its own predictor.
`timescale 1ns / 1ps
module tb_top;
    import nsp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 1500;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [31:0] operand
    logic        s_axis_tuser = 1'b0; // [0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [31:0] value_out

    logic [31:0] expected_roots[$];
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    bit          no_gaps = 1'b0;
    bit          timed_out = 1'b0;

    always #2 i_clk = ~i_clk;

    newton_sqrt_and_pow075_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // Root of a positive value with FRAC_BITS fraction bits, by scaled Newton steps.
    function automatic logic [31:0] fixed_root(logic [63:0] raw);
        logic [63:0] lo;
        logic [63:0] mant;
        logic [63:0] y;
        logic [63:0] q;
        int down;
        int up;
        int shift;
        lo = 64'd1 << (FRAC_BITS - 1);
        down = 0;
        up = 0;
        if (raw == 0) return '0;
        if (raw > (64'd1 << (FRAC_BITS + 1))) begin
            while (down < SCALE_LIMIT && raw > (64'd1 << (FRAC_BITS + 1 + 2 * down))) down++;
        end else if (raw < lo) begin
            while (up < SCALE_LIMIT && (raw << (2 * up)) < lo) up++;
        end
        shift = MANT_FRAC - FRAC_BITS - 2 * down + 2 * up;
        mant = (shift >= 0) ? (raw << shift) : (raw >> (-shift));
        y = ((64'd1 << MANT_FRAC) + mant) >> 1;
        for (int i = 0; i < NEWTON_STEPS; i++) begin
            q = (y == 0) ? 64'hFFFF_FFFF : (mant << MANT_FRAC) / y;
            y = (y + q) >> 1;
        end
        shift = FRAC_BITS + down - up - MANT_FRAC;
        y = (shift >= 0) ? (y << shift) : (y >> (-shift));
        return y[31:0];
    endfunction

    function automatic logic [31:0] predict_value(logic kind, logic [31:0] operand);
        logic [63:0] s;
        logic [63:0] t;
        logic [63:0] prod;
        if (operand == 0 || operand[31]) return '0;
        s = {32'd0, fixed_root({32'd0, operand})};
        if (kind == KIND_SQRT) return s[31:0];
        t = {32'd0, fixed_root(s)};
        prod = (s * t) >> FRAC_BITS;
        return prod[31:0];
    endfunction

    function automatic bit gap_now();
        return !no_gaps && ($urandom_range(99) < 37);
    endfunction

    // Valid stays up after a transaction until the next item or an idle cycle replaces it.
    task automatic send_item(logic kind, logic [31:0] operand);
        while (gap_now()) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        expected_roots.push_back(predict_value(kind, operand));
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= operand;
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Receiver stalls at random unless the no-gap stretch is running.
    always @(posedge i_clk) begin
        if (i_rst_n) m_axis_tready <= !gap_now();
    end

    always @(posedge i_clk) begin
        logic [31:0] exp_value;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_roots.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result %h", m_axis_tdata);
            end else begin
                exp_value = expected_roots.pop_front();
                if (m_axis_tdata !== exp_value) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("value_out mismatch: expected %h actual %h",
                                 exp_value, m_axis_tdata);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) timed_out <= 1'b1;
    end

    task automatic test_edge_values();
        logic [31:0] vals[14] = '{32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                  32'h0000_0002, 32'h0000_8000, 32'h0001_0000, 32'h0002_0000,
                                  32'h0002_0001, 32'h0004_0000, 32'h7FFF_FFFF, 32'h0000_7FFF,
                                  32'h0009_0000, 32'h4000_0000};
        foreach (vals[i]) begin
            send_item(KIND_SQRT, vals[i]);
            send_item(KIND_POW, vals[i]);
        end
    endtask

    task automatic test_random_operands(int count);
        logic [31:0] operand;
        int sel;
        for (int n = 0; n < count; n++) begin
            no_gaps = (n >= 300 && n < 420);
            sel = $urandom_range(9);
            operand = $urandom();
            // Spread magnitudes so that every scaling depth is reached.
            if (sel < 6) operand = {1'b0, operand[30:0]} >> $urandom_range(31);
            else if (sel == 6) operand = operand | 32'h8000_0000;
            send_item(1'($urandom_range(1)), operand);
        end
        no_gaps = 1'b0;
    endtask

    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (expected_roots.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_edge_values();
        test_random_operands(922);
        wait_for_drain();
        if (mismatch_count == 0 && expected_roots.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        wait (timed_out);
        $display("simulation failed");
        $finish;
    end
endmodule

// File: filelist.f
design/nsp_pkg.sv
design/nsp_divider.sv
design/nsp_multiplier.sv
design/newton_sqrt_and_pow075_core.sv
verif/tb_top.sv
